// File: src/lobm_pkg.sv
// Shared constants, payload types and codes of the order book matcher.
`timescale 1ns / 1ps
package lobm_pkg;

  // Book geometry.
  localparam int PriceLevels = 256;
  localparam int OrderSlots  = 64;
  localparam int LvlW        = $clog2(PriceLevels);
  localparam int SlotW       = $clog2(OrderSlots);
  localparam int CntW        = $clog2(OrderSlots + 1);
  localparam int HtW         = 2 * SlotW;

  // Command codes.
  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_CANCEL = 3'd1,
    FUNC_MODIFY = 3'd2,
    FUNC_LIMIT  = 3'd3,
    FUNC_MARKET = 3'd4
  } func_t;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_ID    = 2'd1;
  localparam logic [1:0] STAT_BAND     = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // Input beat.
  typedef struct packed {
    logic [2:0]  func;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] order_id;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic        is_trade;
    logic [31:0] trade_price;
    logic [31:0] fill_quantity;
    logic [31:0] maker_id;
    logic [1:0]  status;
    logic [31:0] remaining;
    logic        last;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [2:0]      func;
    logic            side;
    logic            in_band;
    logic [LvlW-1:0] level;
    logic [31:0]     limit;
    logic [31:0]     qty;
    logic [31:0]     id;
  } cmd_t;

endpackage

// File: src/lobm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module lobm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  // Write first in program order, read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/lobm_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module lobm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         base_price,
  input  logic                in_valid,
  output logic                in_ready,
  input  lobm_pkg::in_item_t  in_data,
  output logic                q_valid,
  input  logic                q_pop,
  output lobm_pkg::cmd_t      q_data
);

  logic [32:0]    diff;
  lobm_pkg::cmd_t cls;
  lobm_pkg::cmd_t ent_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;

  // Band check without wrap, and the limit used for crossing.
  assign diff = {1'b0, in_data.price} - {1'b0, base_price};

  always_comb begin
    cls.func    = in_data.func;
    cls.side    = in_data.side;
    cls.in_band = !diff[32] && (diff[31:0] < 32'(lobm_pkg::PriceLevels));
    cls.level   = diff[lobm_pkg::LvlW-1:0];
    cls.qty     = in_data.quantity;
    cls.id      = in_data.order_id;
    if (in_data.func == lobm_pkg::FUNC_MARKET) begin
      cls.limit = in_data.side ? 32'd0 : 32'hFFFF_FFFF;
    end else begin
      cls.limit = in_data.price;
    end
  end

  // Two-entry queue between the halves.
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: src/lobm_back.sv
// Back end: sequencer that executes commands against the book and emits result beats.
`timescale 1ns / 1ps
module lobm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         base_price,
  input  logic                q_valid,
  output logic                q_pop,
  input  lobm_pkg::cmd_t      q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lobm_pkg::out_item_t out_data
);

  localparam int LvlW  = lobm_pkg::LvlW;
  localparam int SlotW = lobm_pkg::SlotW;
  localparam int CntW  = lobm_pkg::CntW;
  localparam int HtW   = lobm_pkg::HtW;
  localparam int NLvl  = lobm_pkg::PriceLevels;
  localparam int NSlot = lobm_pkg::OrderSlots;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'h0001,
    ST_FREE    = 15'h0002,
    ST_RST_A   = 15'h0004,
    ST_RST_B   = 15'h0008,
    ST_FIND    = 15'h0010,
    ST_MCHK    = 15'h0020,
    ST_MHT     = 15'h0040,
    ST_MQ      = 15'h0080,
    ST_RM_A    = 15'h0100,
    ST_RM_B    = 15'h0200,
    ST_RM_C    = 15'h0400,
    ST_RM_WALK = 15'h0800,
    ST_RM_STEP = 15'h1000,
    ST_RESCAN  = 15'h2000,
    ST_FIN     = 15'h4000
  } state_t;

  // Control registers.
  state_t             state_r, state_nxt;
  logic [NLvl-1:0]    bid_occ_r, bid_occ_nxt;
  logic [NLvl-1:0]    ask_occ_r, ask_occ_nxt;
  logic [NSlot-1:0]   valid_r, valid_nxt;
  logic               bid_v_r, bid_v_nxt;
  logic               ask_v_r, ask_v_nxt;
  logic [LvlW-1:0]    bid_idx_r, bid_idx_nxt;
  logic [LvlW-1:0]    ask_idx_r, ask_idx_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic               out_v_r, out_v_nxt;
  logic               fk_v_r, fk_v_nxt;
  logic [CntW-1:0]    n_r, n_nxt;

  // Working registers.
  lobm_pkg::cmd_t     cmd_r, cmd_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic [SlotW-1:0]   scan_r, scan_nxt;
  logic [SlotW-1:0]   fk_r, fk_nxt;
  logic [SlotW-1:0]   k_r, k_nxt;
  logic [SlotW-1:0]   m_r, m_nxt;
  logic               ret_match_r, ret_match_nxt;
  logic [SlotW-1:0]   rm_k_r, rm_k_nxt;
  logic               rm_s_r, rm_s_nxt;
  logic [LvlW-1:0]    rm_l_r, rm_l_nxt;
  logic [SlotW-1:0]   nx_r, nx_nxt;
  logic [SlotW-1:0]   head_r, head_nxt;
  logic [SlotW-1:0]   tail_r, tail_nxt;
  logic [SlotW-1:0]   cur_r, cur_nxt;
  logic [SlotW-1:0]   prev_r, prev_nxt;
  logic               prev_v_r, prev_v_nxt;
  logic               rs_side_r, rs_side_nxt;
  logic [LvlW-1:0]    lvl_r, lvl_nxt;
  lobm_pkg::out_item_t pend_r, pend_nxt;
  lobm_pkg::out_item_t out_r, out_nxt;

  // RAM ports.
  logic             id_we, qty_we, ls_we, nx_we, ht_we;
  logic [SlotW-1:0] id_waddr, id_raddr, qty_waddr, qty_raddr;
  logic [SlotW-1:0] ls_waddr, ls_raddr, nx_waddr, nx_raddr;
  logic [31:0]      id_wdata, id_rd, qty_wdata, qty_rd;
  logic [LvlW:0]    ls_wdata, ls_rd;
  logic [SlotW-1:0] nx_wdata, nx_rd;
  logic [LvlW:0]    ht_waddr, ht_raddr;
  logic [HtW-1:0]   ht_wdata, ht_rd;

  // Datapath helpers.
  logic             opp;
  logic             bv;
  logic [LvlW-1:0]  bi;
  logic [31:0]      ap;
  logic             cross_ok;
  logic [31:0]      fill;
  logic [31:0]      rest_qty;
  logic             out_free;
  logic             out_load;
  logic             occ_here;
  logic             occ_scan;
  logic             occ_clr;
  logic             best_hit;
  state_t           ret_state;

  lobm_ram #(.Width(32), .Depth(NSlot)) u_id_ram (
    .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
    .raddr(id_raddr), .rdata(id_rd)
  );
  lobm_ram #(.Width(32), .Depth(NSlot)) u_qty_ram (
    .clk(clk), .we(qty_we), .waddr(qty_waddr), .wdata(qty_wdata),
    .raddr(qty_raddr), .rdata(qty_rd)
  );
  lobm_ram #(.Width(LvlW + 1), .Depth(NSlot)) u_ls_ram (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
    .raddr(ls_raddr), .rdata(ls_rd)
  );
  lobm_ram #(.Width(SlotW), .Depth(NSlot)) u_nx_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rd)
  );
  lobm_ram #(.Width(HtW), .Depth(2 * NLvl)) u_ht_ram (
    .clk(clk), .we(ht_we), .waddr(ht_waddr), .wdata(ht_wdata),
    .raddr(ht_raddr), .rdata(ht_rd)
  );

  // Best opposite level and the cross test against the taker limit.
  assign opp      = ~cmd_r.side;
  assign bv       = opp ? ask_v_r : bid_v_r;
  assign bi       = opp ? ask_idx_r : bid_idx_r;
  assign ap       = base_price + 32'(bi);
  assign cross_ok = cmd_r.side ? !(ap < cmd_r.limit) : !(ap > cmd_r.limit);
  assign fill     = (rem_r < qty_rd) ? rem_r : qty_rd;
  assign rest_qty = (cmd_r.func == lobm_pkg::FUNC_ADD) ? cmd_r.qty : rem_r;
  assign out_free = !out_v_r || out_ready;
  assign occ_here = cmd_r.side ? ask_occ_r[cmd_r.level] : bid_occ_r[cmd_r.level];
  assign occ_scan = rs_side_r ? ask_occ_r[lvl_r] : bid_occ_r[lvl_r];
  assign best_hit = rm_s_r ? (ask_v_r && ask_idx_r == rm_l_r)
                           : (bid_v_r && bid_idx_r == rm_l_r);
  assign ret_state = ret_match_r ? ST_MCHK : ST_FIN;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    bid_occ_nxt   = bid_occ_r;
    ask_occ_nxt   = ask_occ_r;
    valid_nxt     = valid_r;
    bid_v_nxt     = bid_v_r;
    ask_v_nxt     = ask_v_r;
    bid_idx_nxt   = bid_idx_r;
    ask_idx_nxt   = ask_idx_r;
    pend_v_nxt    = pend_v_r;
    fk_v_nxt      = fk_v_r;
    n_nxt         = n_r;
    cmd_nxt       = cmd_r;
    rem_nxt       = rem_r;
    stat_nxt      = stat_r;
    scan_nxt      = scan_r;
    fk_nxt        = fk_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    ret_match_nxt = ret_match_r;
    rm_k_nxt      = rm_k_r;
    rm_s_nxt      = rm_s_r;
    rm_l_nxt      = rm_l_r;
    nx_nxt        = nx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_v_nxt    = prev_v_r;
    rs_side_nxt   = rs_side_r;
    lvl_nxt       = lvl_r;
    pend_nxt      = pend_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_nxt       = out_r;
    occ_clr       = 1'b0;
    id_we = 1'b0;  id_waddr = '0;  id_wdata = '0;  id_raddr = '0;
    qty_we = 1'b0; qty_waddr = '0; qty_wdata = '0; qty_raddr = '0;
    ls_we = 1'b0;  ls_waddr = '0;  ls_wdata = '0;  ls_raddr = '0;
    nx_we = 1'b0;  nx_waddr = '0;  nx_wdata = '0;  nx_raddr = '0;
    ht_we = 1'b0;  ht_waddr = '0;  ht_wdata = '0;  ht_raddr = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_data;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          stat_nxt   = lobm_pkg::STAT_OK;
          rem_nxt    = '0;
          scan_nxt   = '0;
          fk_v_nxt   = 1'b0;
          unique case (q_data.func) inside
            lobm_pkg::FUNC_ADD: begin
              if (!q_data.in_band) begin
                stat_nxt  = lobm_pkg::STAT_BAND;
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_FREE;
              end
            end
            lobm_pkg::FUNC_CANCEL, lobm_pkg::FUNC_MODIFY: begin
              state_nxt = ST_FIND;
            end
            lobm_pkg::FUNC_LIMIT, lobm_pkg::FUNC_MARKET: begin
              rem_nxt   = q_data.qty;
              state_nxt = ST_MCHK;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      // Lowest free slot, one valid bit a cycle.
      ST_FREE: begin
        if (!valid_r[scan_r]) begin
          k_nxt     = scan_r;
          state_nxt = ST_RST_A;
        end else if (scan_r == SlotW'(NSlot - 1)) begin
          stat_nxt  = lobm_pkg::STAT_FULL;
          state_nxt = ST_FIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      // Fill the slot and either open the level or fetch its tail.
      ST_RST_A: begin
        id_we     = 1'b1; id_waddr  = k_r; id_wdata  = cmd_r.id;
        qty_we    = 1'b1; qty_waddr = k_r; qty_wdata = rest_qty;
        ls_we     = 1'b1; ls_waddr  = k_r; ls_wdata  = {cmd_r.side, cmd_r.level};
        valid_nxt[k_r] = 1'b1;
        ht_raddr  = {cmd_r.side, cmd_r.level};
        if (!occ_here) begin
          ht_we    = 1'b1;
          ht_waddr = {cmd_r.side, cmd_r.level};
          ht_wdata = {k_r, k_r};
          if (cmd_r.side) begin
            ask_occ_nxt[cmd_r.level] = 1'b1;
            if (!ask_v_r || cmd_r.level < ask_idx_r) begin
              ask_v_nxt   = 1'b1;
              ask_idx_nxt = cmd_r.level;
            end
          end else begin
            bid_occ_nxt[cmd_r.level] = 1'b1;
            if (!bid_v_r || cmd_r.level > bid_idx_r) begin
              bid_v_nxt   = 1'b1;
              bid_idx_nxt = cmd_r.level;
            end
          end
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_RST_B;
        end
      end

      // Append behind the current tail.
      ST_RST_B: begin
        nx_we     = 1'b1;
        nx_waddr  = ht_rd[SlotW-1:0];
        nx_wdata  = k_r;
        ht_we     = 1'b1;
        ht_waddr  = {cmd_r.side, cmd_r.level};
        ht_wdata  = {ht_rd[HtW-1:SlotW], k_r};
        state_nxt = ST_FIN;
      end

      // Id search: the address is issued in the cycle before its compare.
      ST_FIND: begin
        id_raddr = scan_r;
        if (fk_v_r && valid_r[fk_r] && id_rd == cmd_r.id) begin
          if (cmd_r.func == lobm_pkg::FUNC_CANCEL) begin
            rm_k_nxt      = fk_r;
            ret_match_nxt = 1'b0;
            state_nxt     = ST_RM_A;
          end else begin
            qty_we    = 1'b1;
            qty_waddr = fk_r;
            qty_wdata = cmd_r.qty;
            state_nxt = ST_FIN;
          end
        end else if (fk_v_r && fk_r == SlotW'(NSlot - 1)) begin
          stat_nxt  = lobm_pkg::STAT_NO_ID;
          state_nxt = ST_FIN;
        end else begin
          fk_nxt   = scan_r;
          fk_v_nxt = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end
      end

      // Decide whether the taker keeps crossing.
      ST_MCHK: begin
        ht_raddr = {opp, bi};
        if (rem_r == 32'd0 || n_r == CntW'(NSlot) || !bv || !cross_ok) begin
          if (cmd_r.func == lobm_pkg::FUNC_LIMIT && rem_r != 32'd0) begin
            if (!cmd_r.in_band) begin
              stat_nxt  = lobm_pkg::STAT_BAND;
              state_nxt = ST_FIN;
            end else begin
              scan_nxt  = '0;
              state_nxt = ST_FREE;
            end
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          state_nxt = ST_MHT;
        end
      end

      ST_MHT: begin
        m_nxt     = ht_rd[HtW-1:SlotW];
        id_raddr  = ht_rd[HtW-1:SlotW];
        qty_raddr = ht_rd[HtW-1:SlotW];
        state_nxt = ST_MQ;
      end

      // One fill against the head maker; the previous trade goes out now.
      ST_MQ: begin
        id_raddr  = m_r;
        qty_raddr = m_r;
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_load = 1'b1;
            out_nxt  = pend_r;
          end
          pend_v_nxt             = 1'b1;
          pend_nxt.is_trade      = 1'b1;
          pend_nxt.trade_price   = ap;
          pend_nxt.fill_quantity = fill;
          pend_nxt.maker_id      = id_rd;
          pend_nxt.status        = lobm_pkg::STAT_OK;
          pend_nxt.remaining     = '0;
          pend_nxt.last          = 1'b0;
          n_nxt   = n_r + 1'b1;
          rem_nxt = rem_r - fill;
          if (fill == qty_rd) begin
            rm_k_nxt      = m_r;
            ret_match_nxt = 1'b1;
            state_nxt     = ST_RM_A;
          end else begin
            qty_we    = 1'b1;
            qty_waddr = m_r;
            qty_wdata = qty_rd - fill;
            state_nxt = ST_MCHK;
          end
        end
      end

      // Unlink a slot from its level queue.
      ST_RM_A: begin
        ls_raddr  = rm_k_r;
        nx_raddr  = rm_k_r;
        state_nxt = ST_RM_B;
      end

      ST_RM_B: begin
        rm_s_nxt  = ls_rd[LvlW];
        rm_l_nxt  = ls_rd[LvlW-1:0];
        nx_nxt    = nx_rd;
        ht_raddr  = ls_rd;
        state_nxt = ST_RM_C;
      end

      ST_RM_C: begin
        head_nxt   = ht_rd[HtW-1:SlotW];
        tail_nxt   = ht_rd[SlotW-1:0];
        cur_nxt    = ht_rd[HtW-1:SlotW];
        prev_v_nxt = 1'b0;
        state_nxt  = ST_RM_WALK;
      end

      ST_RM_WALK: begin
        if (cur_r == rm_k_r) begin
          if (cur_r == tail_r) begin
            if (!prev_v_r) begin
              occ_clr = 1'b1;
              if (rm_s_r) begin
                ask_occ_nxt[rm_l_r] = 1'b0;
              end else begin
                bid_occ_nxt[rm_l_r] = 1'b0;
              end
            end else begin
              ht_we    = 1'b1;
              ht_waddr = {rm_s_r, rm_l_r};
              ht_wdata = {head_r, prev_r};
            end
          end else if (!prev_v_r) begin
            ht_we    = 1'b1;
            ht_waddr = {rm_s_r, rm_l_r};
            ht_wdata = {nx_r, tail_r};
          end else begin
            nx_we    = 1'b1;
            nx_waddr = prev_r;
            nx_wdata = nx_r;
          end
          valid_nxt[rm_k_r] = 1'b0;
          if (occ_clr && best_hit) begin
            rs_side_nxt = rm_s_r;
            lvl_nxt     = rm_s_r ? '0 : '1;
            state_nxt   = ST_RESCAN;
          end else begin
            state_nxt = ret_state;
          end
        end else if (cur_r == tail_r) begin
          valid_nxt[rm_k_r] = 1'b0;
          state_nxt         = ret_state;
        end else begin
          prev_nxt   = cur_r;
          prev_v_nxt = 1'b1;
          nx_raddr   = cur_r;
          state_nxt  = ST_RM_STEP;
        end
      end

      ST_RM_STEP: begin
        cur_nxt   = nx_rd;
        state_nxt = ST_RM_WALK;
      end

      // New best level, one occupancy bit a cycle.
      ST_RESCAN: begin
        if (occ_scan) begin
          if (rs_side_r) begin
            ask_v_nxt   = 1'b1;
            ask_idx_nxt = lvl_r;
          end else begin
            bid_v_nxt   = 1'b1;
            bid_idx_nxt = lvl_r;
          end
          state_nxt = ret_state;
        end else if (rs_side_r ? (lvl_r == '1) : (lvl_r == '0)) begin
          if (rs_side_r) begin
            ask_v_nxt = 1'b0;
          end else begin
            bid_v_nxt = 1'b0;
          end
          state_nxt = ret_state;
        end else begin
          lvl_nxt = rs_side_r ? lvl_r + 1'b1 : lvl_r - 1'b1;
        end
      end

      // Final beat carries status and remainder.
      ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_v_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt = '0;
          end
          out_nxt.status    = stat_r;
          out_nxt.remaining = rem_r;
          out_nxt.last      = 1'b1;
          pend_v_nxt        = 1'b0;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bid_occ_r <= '0;
      ask_occ_r <= '0;
      valid_r   <= '0;
      bid_v_r   <= 1'b0;
      ask_v_r   <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      fk_v_r    <= 1'b0;
      n_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      bid_occ_r <= bid_occ_nxt;
      ask_occ_r <= ask_occ_nxt;
      valid_r   <= valid_nxt;
      bid_v_r   <= bid_v_nxt;
      ask_v_r   <= ask_v_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
      fk_v_r    <= fk_v_nxt;
      n_r       <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bid_idx_r   <= bid_idx_nxt;
    ask_idx_r   <= ask_idx_nxt;
    cmd_r       <= cmd_nxt;
    rem_r       <= rem_nxt;
    stat_r      <= stat_nxt;
    scan_r      <= scan_nxt;
    fk_r        <= fk_nxt;
    k_r         <= k_nxt;
    m_r         <= m_nxt;
    ret_match_r <= ret_match_nxt;
    rm_k_r      <= rm_k_nxt;
    rm_s_r      <= rm_s_nxt;
    rm_l_r      <= rm_l_nxt;
    nx_r        <= nx_nxt;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    prev_v_r    <= prev_v_nxt;
    rs_side_r   <= rs_side_nxt;
    lvl_r       <= lvl_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
  end

  // Between commands a tracked best level is always occupied.
  a_bid_best_occ : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && bid_v_r) |-> bid_occ_r[bid_idx_r])
    else $error("best bid points at an empty level");

  a_ask_best_occ : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && ask_v_r) |-> ask_occ_r[ask_idx_r])
    else $error("best ask points at an empty level");

  // A beat is only loaded when the output register has room.
  a_out_room : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_v_r || out_ready))
    else $error("result beat overwrote a waiting beat");

  // Fill count stays within the slot pool.
  a_fill_count : assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CntW'(NSlot))
    else $error("more fills than resting slots");

endmodule

// File: src/limit_order_book_matcher_top.sv
// Add: the free-slot search takes one valid bit a cycle.
// Cancel and modify: an id search, then on removal a walk along the level queue,
// plus a best-level rescan when a best level empties.
// Limit and market: each fill passes MCHK, MHT and MQ; a used-up maker is removed as above.
// The back end takes one item at a time; a waiting item is taken in the cycle after the last beat is loaded.
// Reset (rst_n, synchronous): book empty, no best bid or ask, base price zero.
`timescale 1ns / 1ps
module limit_order_book_matcher_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lobm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lobm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  logic [31:0]    base_price_r;
  logic           q_valid;
  logic           q_pop;
  lobm_pkg::cmd_t q_data;

  // Base price register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_price_r <= '0;
    end else if (cfg_we) begin
      base_price_r <= cfg_wdata;
    end
  end

  lobm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .base_price(base_price_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data)
  );

  lobm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .base_price(base_price_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
